// File: rtl/core/ccr_pkg.sv
// Shared types, constants and the binomial row builder for the colex ranker.
package ccr_pkg;

    localparam int RANK_W   = 61;
    localparam int COUNT_W  = 7;
    localparam int MASK_W   = 64;
    localparam int LANE_W   = 8;
    localparam int LCNT_W   = $clog2(LANE_W + 1);
    localparam int BINOM_K  = 65;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_ORBITAL  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OCCUPIED = 1'b1;

    localparam logic [COUNT_W-1:0] ORBITAL_RST  = 7'd64;
    localparam logic [COUNT_W-1:0] OCCUPIED_RST = 7'd32;

    typedef logic [RANK_W-1:0]  t_rank;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [LCNT_W-1:0]  t_lane_cnt;
    typedef logic [BINOM_K-1:0][RANK_W-1:0] t_binom_row;

    function automatic t_binom_row pascal_row(input int n);
        t_binom_row row;
        row    = '0;
        row[0] = t_rank'(1);
        for (int r = 1; r <= n; r++) begin
            for (int k = BINOM_K - 1; k >= 1; k--) begin
                row[k] = row[k] + row[k-1];
            end
        end
        return row;
    endfunction

endpackage

// File: rtl/core/colex_combination_ranker_top.sv
// Top level of the colex combination ranker: config, masking, lane bases, lanes, merge.
//
// Input channel i_in_valid / o_in_ready carries one 64-bit occupancy mask per beat.
// Output channel o_out_valid / i_out_ready returns one 61-bit colex rank per mask,
// in order. Config channel i_cfg_valid / o_cfg_ready writes orbital_count (index 0)
// or occupied_count (index 1) from i_cfg_data; it is always ready. The user must write it
// only while no mask is in flight; the block itself does not enforce this.
// Throughput: one mask per cycle while the result beat is not stalled. With 64
// positions there are eight 8-bit lanes, a three-level lane adder tree and a
// three-level merge tree.
// Pipeline: width mask, lane popcounts, lane base counts, lane binomial terms,
// lane sum tree, merge tree, output register.
// Reset clears all valid flags and loads orbital_count = 64, occupied_count = 32.
// When the receiver stalls a valid result, the whole pipeline holds and
// o_in_ready drops; it resumes in the cycle the result beat is taken.
module colex_combination_ranker_top #(
    parameter int MAX_POSITIONS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [ccr_pkg::MASK_W-1:0]          i_occupancy_mask,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [ccr_pkg::RANK_W-1:0]          o_rank,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ccr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ccr_pkg::COUNT_W-1:0]         i_cfg_data
);

    localparam int NL    = (MAX_POSITIONS + ccr_pkg::LANE_W - 1) / ccr_pkg::LANE_W;
    localparam int LV_M  = (NL > 1) ? $clog2(NL) : 0;
    localparam int DEPTH = 7 + LV_M;
    localparam ccr_pkg::t_count MAX_POS = ccr_pkg::t_count'(MAX_POSITIONS);

    logic adv;

    ccr_pkg::t_count r_orbital;
    ccr_pkg::t_count r_occupied;

    logic [DEPTH-1:0] r_vpipe;

    ccr_pkg::t_count             w_width;
    logic [ccr_pkg::MASK_W-1:0]  n_s1_mask;
    logic [ccr_pkg::MASK_W-1:0]  r_s1_mask;
    ccr_pkg::t_count             r_s1_occ;

    ccr_pkg::t_lane_cnt          n_s2_cnt [NL];
    ccr_pkg::t_lane_cnt          r_s2_cnt [NL];
    logic [ccr_pkg::MASK_W-1:0]  r_s2_mask;
    ccr_pkg::t_count             r_s2_occ;

    ccr_pkg::t_count             n_s3_base [NL];
    ccr_pkg::t_count             r_s3_base [NL];
    logic [ccr_pkg::MASK_W-1:0]  r_s3_mask;
    ccr_pkg::t_count             r_s3_occ;

    ccr_pkg::t_rank              w_lane_sum [NL];
    ccr_pkg::t_rank              w_merged;

    assign adv         = !o_out_valid || i_out_ready;
    assign o_in_ready  = adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orbital  <= ccr_pkg::ORBITAL_RST;
            r_occupied <= ccr_pkg::OCCUPIED_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ccr_pkg::REG_ORBITAL:  r_orbital  <= i_cfg_data;
                ccr_pkg::REG_OCCUPIED: r_occupied <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_width = (r_orbital > MAX_POS) ? MAX_POS : r_orbital;
        for (int p = 0; p < ccr_pkg::MASK_W; p++) begin
            n_s1_mask[p] = i_occupancy_mask[p] && (ccr_pkg::t_count'(p) < w_width);
        end
    end

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            n_s2_cnt[l] = '0;
            for (int b = 0; b < ccr_pkg::LANE_W; b++) begin
                n_s2_cnt[l] = n_s2_cnt[l]
                            + ccr_pkg::t_lane_cnt'(r_s1_mask[l*ccr_pkg::LANE_W+b]);
            end
        end
    end

    always_comb begin
        n_s3_base[0] = '0;
        for (int l = 1; l < NL; l++) begin
            n_s3_base[l] = n_s3_base[l-1] + ccr_pkg::t_count'(r_s2_cnt[l-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vpipe     <= '0;
            o_out_valid <= 1'b0;
        end else if (adv) begin
            r_vpipe     <= {r_vpipe[DEPTH-2:0], i_in_valid};
            o_out_valid <= r_vpipe[DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_mask <= n_s1_mask;
            r_s1_occ  <= r_occupied;
            r_s2_cnt  <= n_s2_cnt;
            r_s2_mask <= r_s1_mask;
            r_s2_occ  <= r_s1_occ;
            r_s3_base <= n_s3_base;
            r_s3_mask <= r_s2_mask;
            r_s3_occ  <= r_s2_occ;
            o_rank    <= w_merged;
        end
    end

    generate
        for (genvar l = 0; l < NL; l++) begin : g_lane
            ccr_lane #(
                .LANE_BASE (l * ccr_pkg::LANE_W)
            ) u_lane (
                .i_clk  (i_clk),
                .i_en   (adv),
                .i_bits (r_s3_mask[l*ccr_pkg::LANE_W +: ccr_pkg::LANE_W]),
                .i_base (r_s3_base[l]),
                .i_occ  (r_s3_occ),
                .o_sum  (w_lane_sum[l])
            );
        end
    endgenerate

    ccr_sum_tree #(
        .N (NL)
    ) u_merge (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_terms (w_lane_sum),
        .o_sum   (w_merged)
    );

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted while result beat stalled");

    a_accept_enters_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_vpipe[0])
        else $error("accepted mask not tracked in first stage");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && (r_vpipe == '0))
        else $error("valid flags not cleared by reset");

endmodule

// File: rtl/core/ccr_sum_tree.sv
// Pipelined adder tree, one register level per halving.
module ccr_sum_tree #(
    parameter int N = 8
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  ccr_pkg::t_rank i_terms [N],
    output ccr_pkg::t_rank o_sum
);

    localparam int LV = (N > 1) ? $clog2(N) : 0;
    localparam int NP = 1 << LV;

    generate
        if (LV == 0) begin : g_single
            assign o_sum = i_terms[0];
        end else begin : g_tree
            ccr_pkg::t_rank r_node [1:NP-1];
            ccr_pkg::t_rank w_node [1:2*NP-1];

            always_comb begin
                for (int k = 1; k < 2 * NP; k++) begin
                    if (k < NP) begin
                        w_node[k] = r_node[k];
                    end else if (k - NP < N) begin
                        w_node[k] = i_terms[k-NP];
                    end else begin
                        w_node[k] = '0;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    for (int k = 1; k < NP; k++) begin
                        r_node[k] <= w_node[2*k] + w_node[2*k+1];
                    end
                end
            end

            assign o_sum = r_node[1];
        end
    endgenerate

endmodule

// File: rtl/core/ccr_lane.sv
// One ranking lane: set-bit ordinals, binomial lookup and lane sum for eight positions.
module ccr_lane #(
    parameter int LANE_BASE = 0
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [ccr_pkg::LANE_W-1:0]      i_bits,
    input  ccr_pkg::t_count                 i_base,
    input  ccr_pkg::t_count                 i_occ,
    output ccr_pkg::t_rank                  o_sum
);

    ccr_pkg::t_count w_j    [ccr_pkg::LANE_W];
    logic            w_keep [ccr_pkg::LANE_W];
    ccr_pkg::t_rank  w_term [ccr_pkg::LANE_W];
    ccr_pkg::t_rank  r_term [ccr_pkg::LANE_W];

    always_comb begin
        ccr_pkg::t_count run;
        run = i_base;
        for (int b = 0; b < ccr_pkg::LANE_W; b++) begin
            run       = run + ccr_pkg::t_count'(i_bits[b]);
            w_j[b]    = run;
            w_keep[b] = i_bits[b] && (run <= i_occ);
        end
    end

    generate
        for (genvar b = 0; b < ccr_pkg::LANE_W; b++) begin : g_bit
            localparam ccr_pkg::t_binom_row ROW = ccr_pkg::pascal_row(LANE_BASE + b);
            assign w_term[b] = w_keep[b] ? ROW[w_j[b]] : '0;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_term <= w_term;
        end
    end

    ccr_sum_tree #(
        .N (ccr_pkg::LANE_W)
    ) u_sum (
        .i_clk   (i_clk),
        .i_en    (i_en),
        .i_terms (r_term),
        .o_sum   (o_sum)
    );

endmodule
